/* src/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/saes_pkg.sv */
package saes_pkg;

    localparam int BLOCK_W = 16;
    localparam int NIB_W   = 4;
    localparam int BYTE_W  = 8;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [NIB_W-1:0]   t_nib;
    typedef logic [BYTE_W-1:0]  t_byte;

    // Round keys one and two; round key zero is the cipher key itself.
    typedef struct packed {
        t_block rk1;
        t_block rk2;
    } t_round_keys;

    // Mode codes carried with each input word.
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // Key schedule round constants.
    localparam t_byte RCON_1 = 8'h80;
    localparam t_byte RCON_2 = 8'h30;

    // Column mix matrix entries, forward and inverse.
    localparam t_nib MIX_DIAG     = 4'h1;
    localparam t_nib MIX_OFF      = 4'h4;
    localparam t_nib INV_MIX_DIAG = 4'h9;
    localparam t_nib INV_MIX_OFF  = 4'h2;

    // Reduction term of x^4 + x + 1 once the x^4 bit has been dropped.
    localparam t_nib GF_POLY_LOW = 4'h3;

    localparam t_nib SBOX [16] = '{
        4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
        4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
    };

    localparam t_nib INV_SBOX [16] = '{
        4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
        4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
    };

    // Nibble product in GF(2^4) modulo x^4 + x + 1.
    function automatic t_nib gf_mul(input t_nib a, input t_nib b);
        t_nib acc;
        t_nib x;
        acc = '0;
        x   = a;
        for (int i = 0; i < NIB_W; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = {x[NIB_W-2:0], 1'b0} ^ (x[NIB_W-1] ? GF_POLY_LOW : t_nib'(0));
        end
        return acc;
    endfunction

    // Substitute all four nibbles through the forward or inverse table.
    function automatic t_block sub_word(input t_block w, input logic inv);
        t_block r;
        r = '0;
        for (int i = 0; i < BLOCK_W / NIB_W; i++) begin
            r[i*NIB_W +: NIB_W] = inv ? INV_SBOX[w[i*NIB_W +: NIB_W]]
                                      : SBOX[w[i*NIB_W +: NIB_W]];
        end
        return r;
    endfunction

    // Swap the second and fourth nibbles; this is its own inverse.
    function automatic t_block shift_rows(input t_block s);
        return {s[15:12], s[3:0], s[7:4], s[11:8]};
    endfunction

    // Multiply each column by the matrix [diag off; off diag].
    function automatic t_block mix_cols(input t_block s, input t_nib diag, input t_nib off);
        t_nib n0;
        t_nib n1;
        t_nib n2;
        t_nib n3;
        n0 = s[15:12];
        n1 = s[11:8];
        n2 = s[7:4];
        n3 = s[3:0];
        return {gf_mul(diag, n0) ^ gf_mul(off, n1),
                gf_mul(off, n0) ^ gf_mul(diag, n1),
                gf_mul(diag, n2) ^ gf_mul(off, n3),
                gf_mul(off, n2) ^ gf_mul(diag, n3)};
    endfunction

    // Rotate the nibbles of a byte, substitute both and add the round constant.
    function automatic t_byte g_func(input t_byte w, input t_byte rcon);
        return {SBOX[w[3:0]], SBOX[w[7:4]]} ^ rcon;
    endfunction

    function automatic t_round_keys expand_key(input t_block key);
        t_byte w2;
        t_byte w3;
        t_byte w4;
        t_byte w5;
        t_round_keys rk;
        w2 = key[15:8] ^ g_func(key[7:0], RCON_1);
        w3 = w2 ^ key[7:0];
        w4 = w2 ^ g_func(w3, RCON_2);
        w5 = w4 ^ w3;
        rk.rk1 = {w2, w3};
        rk.rk2 = {w4, w5};
        return rk;
    endfunction

endpackage

/* src/saes_in_if.sv */
// Input channel: a mode bit and one block per word.
interface saes_in_if import saes_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   mode;
    t_block block;

    modport source (output valid, output mode, output block, input ready);
    modport sink (input valid, input mode, input block, output ready);
endinterface

/* src/saes_out_if.sv */
// Output channel: one result block per word.
interface saes_out_if import saes_pkg::*; ();
    logic   valid;
    logic   ready;
    t_block result;

    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

/* src/simplified_aes_cipher.sv */
// Simplified AES cipher on 16-bit blocks. Each input word carries a block and a mode bit
// (0 encrypts, 1 decrypts) and produces exactly one result word, in order. The block
// accepts one word per clock while the output is not stalled: acceptance loads the input
// register, and the result register is then loaded from it through the round logic, which
// is the whole path; backpressure on the output stalls both stages. The key is written
// through i_cfg_wr_en and i_cfg_wr_data and is expanded into its round keys in the same
// cycle, so a new key takes effect for the next word; write it only while no word is in
// flight. After reset the key is zero.
module simplified_aes_cipher import saes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  t_block      i_cfg_wr_data,
    saes_in_if.sink     i_in,
    saes_out_if.source  o_out
);

    t_block      r_key;
    t_round_keys r_rk;

    logic        r_s1_valid;
    logic        r_s1_mode;
    t_block      r_s1_block;

    logic        r_out_valid;
    t_block      r_result;
    t_block      n_result;

    logic        out_advance;
    logic        s1_advance;

    // Key register and expanded round keys, updated on a configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_rk  <= expand_key('0);
        end else if (i_cfg_wr_en) begin
            r_key <= i_cfg_wr_data;
            r_rk  <= expand_key(i_cfg_wr_data);
        end
    end

    // Each stage moves when its successor is empty or being emptied.
    assign out_advance = !r_out_valid || o_out.ready;
    assign s1_advance  = !r_s1_valid || out_advance;
    assign i_in.ready  = i_rst_n && s1_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_advance) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (s1_advance && i_in.valid) begin
            r_s1_mode  <= i_in.mode;
            r_s1_block <= i_in.block;
        end
    end

    // Both rounds in one pass; decryption applies the inverse steps in reverse order.
    always_comb begin
        t_block s;
        if (r_s1_mode == MODE_DECRYPT) begin
            s = r_s1_block ^ r_rk.rk2;
            s = sub_word(shift_rows(s), 1'b1);
            s = s ^ r_rk.rk1;
            s = mix_cols(s, INV_MIX_DIAG, INV_MIX_OFF);
            s = sub_word(shift_rows(s), 1'b1);
            s = s ^ r_key;
        end else begin
            s = r_s1_block ^ r_key;
            s = shift_rows(sub_word(s, 1'b0));
            s = mix_cols(s, MIX_DIAG, MIX_OFF);
            s = s ^ r_rk.rk1;
            s = shift_rows(sub_word(s, 1'b0));
            s = s ^ r_rk.rk2;
        end
        n_result = s;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (out_advance && r_s1_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.result = r_result;

endmodule

/* src/saes_checker.sv */
`include "assert_macros.svh"

// Port-level checks on the cipher's handshakes and latency.
module saes_checker import saes_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_block i_result
);

    logic in_accept;
    assign in_accept = i_in_valid && i_in_ready;

    // A stalled result word stays offered.
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result word dropped while stalled")

    // A stalled result word keeps its value.
    `ASSERT_RST(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_result), "result changed while stalled")

    // Reset empties the pipeline.
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid right after reset")

    // An empty output fills only from an earlier accepted input word.
    `ASSERT_RST(a_latency, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(in_accept, 2), "result without a matching input word")

endmodule

bind simplified_aes_cipher saes_checker u_saes_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_result    (o_out.result)
);
